// ===== rtl/gkn_pkg.sv =====
// Shared types and constants for the Gower k-nearest-donor search.
// Used by gkn_term, gkn_cell, gower_k_nearest_donors_top and the testbench; no dependencies.
package gkn_pkg;

  localparam int VAL_W  = 32;
  localparam int W_W    = 16;
  localparam int DIST_W = 48;
  localparam int TERM_W = 40;
  localparam int CNT_W  = 7;
  localparam int K_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 128;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Variable kinds.
  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_NUM  = 3'd1;
  localparam logic [2:0] CLS_CAT  = 3'd2;
  localparam logic [2:0] CLS_ORD  = 3'd3;
  localparam logic [2:0] CLS_SEMI = 3'd4;

  // How a term is formed.
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_MIS  = 2'd1;
  localparam logic [1:0] KIND_MUL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_NUM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_CAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ORD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SEMI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOURS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WSUM_RECIP = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [TERM_W-1:0] term;
    logic              last_var;
    logic              last_don;
  } term_out_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== rtl/gower_k_nearest_donors_top.sv =====
// Gower k-nearest-donor search: term pipeline, accumulator and sorted cell chain.
// A donor's list insert follows its last variable beat through the term pipeline;
// results start in the cycle after the last donor's insert. Accepts one variable beat per
// cycle unless locked: the last donor's last variable locks input until the k results are taken.
// Reset (rst, synchronous) clears counters, acc, lock and the list; config takes its defaults.
// Depends on gkn_pkg, gkn_term and gkn_cell.
module gower_k_nearest_donors_top import gkn_pkg::*; #(
  parameter int MAX_NEIGHBOURS = 16,
  parameter int MAX_VARIABLES  = 64,
  parameter int MAX_DONORS     = 65536,
  localparam int IDX_W = $clog2(MAX_DONORS + 1),
  localparam int OUT_TDATA_W = ((IDX_W + DIST_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // donor_value, query_value, var_weight, ordered_scale, mixed_value
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,   // last_variable
  input  logic                   s_tuser,   // last_donor
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // donor_index, distance, zero fill
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,   // last_result
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int POS_W = $clog2(MAX_VARIABLES + 1);
  localparam int EMIT_W = $clog2(MAX_NEIGHBOURS + 1);
  localparam int CMP_W = (POS_W > 9 ? POS_W : 9) + 1;

  logic [CNT_W-1:0] count_num, count_cat, count_ord, count_semi;
  logic [K_W-1:0]   neighbours;
  logic [W_W-1:0]   recip;

  logic [POS_W-1:0]  pos;
  logic [IDX_W-1:0]  donor_pos;
  logic [DIST_W-1:0] acc;
  logic              lock;
  logic [EMIT_W-1:0] emit_left;

  logic              accept, beat, final_beat, ins, done_query;
  logic [2:0]        cls;
  logic [CMP_W-1:0]  p, n0, n1, n2, n3;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] acc_next;
  logic [EMIT_W-1:0] k_eff;
  term_out_t         tr;
  cell_ctl_t         ctl;

  assign accept = s_tvalid && s_tready;
  assign s_tready = !lock;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_num  <= '0;
      count_cat  <= '0;
      count_ord  <= '0;
      count_semi <= '0;
      neighbours <= K_W'(1);
      recip      <= {W_W{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT_NUM:  count_num  <= cfg_data[CNT_W-1:0];
        REG_COUNT_CAT:  count_cat  <= cfg_data[CNT_W-1:0];
        REG_COUNT_ORD:  count_ord  <= cfg_data[CNT_W-1:0];
        REG_COUNT_SEMI: count_semi <= cfg_data[CNT_W-1:0];
        REG_NEIGHBOURS: neighbours <= cfg_data[K_W-1:0];
        REG_WSUM_RECIP: recip      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign p  = CMP_W'(pos);
  assign n0 = CMP_W'(count_num);
  assign n1 = n0 + CMP_W'(count_cat);
  assign n2 = n1 + CMP_W'(count_ord);
  assign n3 = n2 + CMP_W'(count_semi);

  always_comb begin
    if (p >= CMP_W'(MAX_VARIABLES)) cls = CLS_NONE;
    else if (p < n0)                cls = CLS_NUM;
    else if (p < n1)                cls = CLS_CAT;
    else if (p < n2)                cls = CLS_ORD;
    else if (p < n3)                cls = CLS_SEMI;
    else                            cls = CLS_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (s_tlast) pos <= '0;
      else if (p < CMP_W'(MAX_VARIABLES)) pos <= pos + 1'b1;
    end
  end

  gkn_term u_term (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .x        (s_tdata[31:0]),
    .y        (s_tdata[63:32]),
    .w        (s_tdata[79:64]),
    .scale    (s_tdata[95:80]),
    .mc       (s_tdata[127:96]),
    .cls      (cls),
    .last_var (s_tlast),
    .last_don (s_tuser),
    .recip    (recip),
    .result   (tr)
  );

  assign sum = {1'b0, acc} + (DIST_W + 1)'(tr.term);
  assign acc_next = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign ins = tr.valid && tr.last_var;
  assign done_query = ins && tr.last_don;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      donor_pos <= '0;
    end else if (tr.valid) begin
      acc <= tr.last_var ? '0 : acc_next;
      if (done_query) donor_pos <= '0;
      else if (ins && donor_pos < IDX_W'(MAX_DONORS - 1)) donor_pos <= donor_pos + 1'b1;
    end
  end

  // Effective k: zero acts as one, large values clamp to the list length.
  always_comb begin
    if (neighbours == '0) k_eff = EMIT_W'(1);
    else if (32'(neighbours) > MAX_NEIGHBOURS) k_eff = EMIT_W'(MAX_NEIGHBOURS);
    else k_eff = EMIT_W'(neighbours);
  end

  assign beat = m_tvalid && m_tready;
  assign final_beat = beat && m_tlast;
  assign m_tvalid = (emit_left != '0);
  assign m_tlast = (emit_left == EMIT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      lock      <= 1'b0;
      emit_left <= '0;
    end else begin
      if (accept && s_tlast && s_tuser) lock <= 1'b1;
      else if (final_beat) lock <= 1'b0;
      if (done_query) emit_left <= k_eff;
      else if (beat) emit_left <= emit_left - 1'b1;
    end
  end

  assign ctl.insert = ins;
  assign ctl.shift  = beat;
  assign ctl.clear  = final_beat;

  logic              c_take  [MAX_NEIGHBOURS];
  logic              c_valid [MAX_NEIGHBOURS];
  logic [DIST_W-1:0] c_dist  [MAX_NEIGHBOURS];
  logic [IDX_W-1:0]  c_idx   [MAX_NEIGHBOURS];

  for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
    logic              pt, pv, nv;
    logic [DIST_W-1:0] pd, nd;
    logic [IDX_W-1:0]  pi, ni;
    if (i == 0) begin : g_head
      assign pt = 1'b0;
      assign pv = 1'b0;
      assign pd = DIST_MAX;
      assign pi = '0;
    end else begin : g_body
      assign pt = c_take[i-1];
      assign pv = c_valid[i-1];
      assign pd = c_dist[i-1];
      assign pi = c_idx[i-1];
    end
    if (i == MAX_NEIGHBOURS - 1) begin : g_tail
      assign nv = 1'b0;
      assign nd = DIST_MAX;
      assign ni = '0;
    end else begin : g_link
      assign nv = c_valid[i+1];
      assign nd = c_dist[i+1];
      assign ni = c_idx[i+1];
    end
    gkn_cell #(.IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_dist   (acc_next),
      .new_idx    (donor_pos + 1'b1),
      .prev_take  (pt),
      .prev_valid (pv),
      .prev_dist  (pd),
      .prev_idx   (pi),
      .next_valid (nv),
      .next_dist  (nd),
      .next_idx   (ni),
      .take       (c_take[i]),
      .valid      (c_valid[i]),
      .cur_dist   (c_dist[i]),
      .idx        (c_idx[i])
    );
  end

  assign m_tdata = OUT_TDATA_W'({c_dist[0], c_idx[0]});

`ifndef ASSERT_OFF
  a_no_input_while_emitting: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted during result emission");

  a_emission_ends: assert property (@(posedge clk) disable iff (rst)
    final_beat |=> !m_tvalid)
    else $error("results continue after the last beat");

  a_empty_slot_reads_max: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !c_valid[0]) |-> (c_dist[0] == DIST_MAX && c_idx[0] == '0))
    else $error("unfilled slot does not read as empty");

  a_insert_not_during_emit: assert property (@(posedge clk) disable iff (rst)
    ins |-> !m_tvalid)
    else $error("list insert while results are draining");
`endif

endmodule

// ===== rtl/gkn_term.sv =====
// Four-stage pipeline that turns one variable pair into its weighted Gower term.
// Depends on gkn_pkg.
module gkn_term import gkn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [VAL_W-1:0] x,
  input  logic signed [VAL_W-1:0] y,
  input  logic [W_W-1:0]          w,
  input  logic [W_W-1:0]          scale,
  input  logic signed [VAL_W-1:0] mc,
  input  logic [2:0]              cls,
  input  logic                    last_var,
  input  logic                    last_don,
  input  logic [W_W-1:0]          recip,
  output term_out_t               result
);

  // Stage 1: registered inputs.
  logic                    v1, lv1, ld1;
  logic signed [VAL_W-1:0] x1, y1, mc1;
  logic [W_W-1:0]          w1, s1;
  logic [2:0]              c1;
  // Stage 2: difference, weight product, compares.
  logic                    v2, lv2, ld2, neq2, xs2, ys2;
  logic [VAL_W-1:0]        d2;
  logic [2*W_W-1:0]        wr2;
  logic [W_W-1:0]          s2;
  logic [2:0]              c2;
  // Stage 3: operand and kind.
  logic                    v3, lv3, ld3;
  logic [VAL_W-1:0]        op3;
  logic [2*W_W-1:0]        wr3;
  logic [1:0]              k3;

  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          mag;
  logic [VAL_W+W_W-1:0]    dscaled;
  logic [2*VAL_W-1:0]      prod;
  logic [1:0]              kind;

  assign diff = {x1[VAL_W-1], x1} - {y1[VAL_W-1], y1};
  assign mag  = diff[VAL_W] ? -diff : diff;
  assign dscaled = d2 * s2;
  assign prod = wr3 * op3;

  always_comb begin
    kind = KIND_ZERO;
    case (c2) inside
      CLS_NUM, CLS_ORD: kind = KIND_MUL;
      CLS_CAT:          kind = neq2 ? KIND_MIS : KIND_ZERO;
      CLS_SEMI: begin
        if (xs2 != ys2) kind = KIND_MIS;
        else if (!xs2)  kind = KIND_MUL;
        else            kind = KIND_ZERO;
      end
      default:          kind = KIND_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      result.valid <= v3;
    end
    x1 <= x; y1 <= y; mc1 <= mc; w1 <= w; s1 <= scale; c1 <= cls;
    lv1 <= last_var; ld1 <= last_don;

    d2   <= mag[VAL_W-1:0];
    wr2  <= w1 * recip;
    s2   <= s1;
    c2   <= c1;
    neq2 <= (x1 != y1);
    xs2  <= (x1 == mc1);
    ys2  <= (y1 == mc1);
    lv2  <= lv1; ld2 <= ld1;

    op3 <= (c2 == CLS_ORD) ? dscaled[VAL_W+W_W-1:W_W] : d2;
    wr3 <= wr2;
    k3  <= kind;
    lv3 <= lv2; ld3 <= ld2;

    case (k3)
      KIND_MUL: result.term <= prod[TERM_W+23:24];
      KIND_MIS: result.term <= TERM_W'(wr3[2*W_W-1:8]);
      default:  result.term <= '0;
    endcase
    result.last_var <= lv3;
    result.last_don <= ld3;
  end

endmodule

// ===== rtl/gkn_cell.sv =====
// One entry of the sorted nearest-donor list; cells form a shifting chain.
// Depends on gkn_pkg.
module gkn_cell import gkn_pkg::*; #(
  parameter int IDX_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [DIST_W-1:0] new_dist,
  input  logic [IDX_W-1:0]  new_idx,
  input  logic              prev_take,
  input  logic              prev_valid,
  input  logic [DIST_W-1:0] prev_dist,
  input  logic [IDX_W-1:0]  prev_idx,
  input  logic              next_valid,
  input  logic [DIST_W-1:0] next_dist,
  input  logic [IDX_W-1:0]  next_idx,
  output logic              take,
  output logic              valid,
  output logic [DIST_W-1:0] cur_dist,
  output logic [IDX_W-1:0]  idx
);

  // Strict compare keeps an equal distance behind the earlier donor.
  assign take = ctl.insert && (!valid || new_dist < cur_dist);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid    <= 1'b0;
      cur_dist <= DIST_MAX;
      idx      <= '0;
    end else if (ctl.shift) begin
      valid    <= next_valid;
      cur_dist <= next_dist;
      idx      <= next_idx;
    end else if (take) begin
      if (prev_take) begin
        valid    <= prev_valid;
        cur_dist <= prev_dist;
        idx      <= prev_idx;
      end else begin
        valid    <= 1'b1;
        cur_dist <= new_dist;
        idx      <= new_idx;
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for gower_k_nearest_donors_top: streams query/donor records,
// predicts the k nearest donors per query and checks every result beat.
// Depends on gkn_pkg and the RTL of gower_k_nearest_donors_top.
`timescale 1ns / 100ps

module testbench import gkn_pkg::*; ();

  localparam int NB_MAX    = 16;
  localparam int VAR_MAX   = 64;
  localparam int DONOR_MAX = 65536;
  localparam int OUT_W     = 72;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_COUNT  = 410;

  typedef struct {
    bit [16:0] index;
    bit [47:0] distance;
    bit        last;
  } neighbour_t;

  // Predicts the ranked donor list and checks result beats against it.
  class gower_ranker;
    bit [6:0]  n_num, n_cat, n_ord, n_semi;
    bit [4:0]  k_reg;
    bit [15:0] recip;
    int        var_pos, donor_pos, fill;
    bit [63:0] acc;
    bit [47:0] best_dist [NB_MAX];
    bit [16:0] best_idx [NB_MAX];
    neighbour_t pending_neighbours[$];
    int        mismatches;

    function new();
      n_num = 0; n_cat = 0; n_ord = 0; n_semi = 0;
      k_reg = 1; recip = 16'hFFFF;
      var_pos = 0; donor_pos = 0; acc = 0;
      mismatches = 0;
      clear_list();
    endfunction

    function void clear_list();
      for (int i = 0; i < NB_MAX; i++) begin
        best_dist[i] = '1;
        best_idx[i] = 0;
      end
      fill = 0;
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [15:0] val);
      case (idx)
        REG_COUNT_NUM:  n_num = val[6:0];
        REG_COUNT_CAT:  n_cat = val[6:0];
        REG_COUNT_ORD:  n_ord = val[6:0];
        REG_COUNT_SEMI: n_semi = val[6:0];
        REG_NEIGHBOURS: k_reg = val[4:0];
        REG_WSUM_RECIP: recip = val;
        default: ;
      endcase
    endfunction

    function bit [63:0] scaled(bit [63:0] w, bit [63:0] d);
      return (w * d * 64'(recip)) >> 24;
    endfunction

    function void insert(bit [47:0] new_dist, bit [16:0] idx);
      int pos;
      pos = 0;
      while (pos < fill && best_dist[pos] <= new_dist) pos++;
      if (pos >= NB_MAX) return;
      for (int i = NB_MAX - 1; i > pos; i--) begin
        best_dist[i] = best_dist[i-1];
        best_idx[i] = best_idx[i-1];
      end
      best_dist[pos] = new_dist;
      best_idx[pos] = idx;
      if (fill < NB_MAX) fill++;
    endfunction

    function void note_variable(bit [31:0] dv, bit [31:0] qv, bit [15:0] w, bit [15:0] sc,
                                bit [31:0] mc, bit lv, bit ld);
      longint    x, y, m;
      bit [63:0] d, term;
      int        b0, b1, b2, b3, k;
      neighbour_t nb;
      bit        xs, ys;
      x = longint'($signed(dv));
      y = longint'($signed(qv));
      m = longint'($signed(mc));
      d = (x >= y) ? 64'(x - y) : 64'(y - x);
      b0 = n_num; b1 = b0 + n_cat; b2 = b1 + n_ord; b3 = b2 + n_semi;
      term = 0;
      if (var_pos < VAR_MAX) begin
        if (var_pos < b0) term = scaled(w, d);
        else if (var_pos < b1) term = (x != y) ? ((64'(w) * 64'(recip)) >> 8) : 0;
        else if (var_pos < b2) term = scaled(w, (d * 64'(sc)) >> 16);
        else if (var_pos < b3) begin
          xs = (x == m);
          ys = (y == m);
          if (xs != ys) term = (64'(w) * 64'(recip)) >> 8;
          else if (!xs) term = scaled(w, d);
        end
        var_pos++;
      end
      acc += term;
      if (acc > 64'hFFFF_FFFF_FFFF) acc = 64'hFFFF_FFFF_FFFF;
      if (lv) begin
        insert(acc[47:0], 17'(donor_pos + 1));
        if (donor_pos < DONOR_MAX - 1) donor_pos++;
        acc = 0;
        var_pos = 0;
        if (ld) begin
          k = k_reg;
          if (k < 1) k = 1;
          if (k > NB_MAX) k = NB_MAX;
          for (int i = 0; i < k; i++) begin
            nb.index    = (i < fill) ? best_idx[i] : 17'd0;
            nb.distance = (i < fill) ? best_dist[i] : 48'hFFFF_FFFF_FFFF;
            nb.last     = (i + 1 == k);
            pending_neighbours.push_back(nb);
          end
          donor_pos = 0;
          clear_list();
        end
      end
    endfunction

    function void check_neighbour(bit [OUT_W-1:0] data, bit last);
      neighbour_t want;
      if (pending_neighbours.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: index %0d dist %h", data[16:0], data[64:17]);
        return;
      end
      want = pending_neighbours.pop_front();
      if (data[16:0] !== want.index || data[64:17] !== want.distance || last !== want.last)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: index %0d/%0d dist %h/%h last %0b/%0b (expected/actual)",
                   want.index, data[16:0], want.distance, data[64:17], want.last, last);
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tlast, s_tuser;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid, m_tready, m_tlast;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gower_k_nearest_donors_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gower_ranker ranker = new();
  int sent_items = 0;
  int idle_mode = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Receiver: checks result beats and throttles m_tready.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) ranker.check_neighbour(m_tdata, m_tlast);
    case (idle_mode)
      0: m_tready <= ($urandom_range(0, 99) >= 49);
      1: m_tready <= ($urandom_range(0, 99) >= 28);
      default: m_tready <= 1'b1;
    endcase
  end

  task automatic send_variable(bit [31:0] dv, bit [31:0] qv, bit [15:0] w, bit [15:0] sc,
                               bit [31:0] mc, bit lv, bit ld);
    int pct;
    pct = (idle_mode == 0) ? 28 : (idle_mode == 1) ? 49 : 0;
    while ($urandom_range(0, 99) < pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {mc, sc, w, qv, dv};
    s_tlast <= lv;
    s_tuser <= ld;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ranker.note_variable(dv, qv, w, sc, mc, lv, ld);
    sent_items++;
    idle_mode = (sent_items < 137) ? 0 : (sent_items < 274) ? 1 : 2;
  endtask

  // Writes all registers; only called while nothing is in flight.
  task automatic configure(bit [6:0] cn, bit [6:0] cc, bit [6:0] co, bit [6:0] cs,
                           bit [4:0] k, bit [15:0] r);
    bit [15:0] vals [6];
    s_tvalid <= 1'b0;
    while (ranker.pending_neighbours.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    vals = '{16'(cn), 16'(cc), 16'(co), 16'(cs), 16'(k), r};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      ranker.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic bit [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 2047) - 1024;
      default: return $urandom;
    endcase
  endfunction

  // One query of random donors; records mostly follow the configured variable total.
  // The query closes early once the item budget is reached.
  task automatic run_query(int donors);
    int total, len, room;
    bit [31:0] dv, qv, mc;
    bit [15:0] w, sc;
    bit lv, fin;
    total = ranker.n_num + ranker.n_cat + ranker.n_ord + ranker.n_semi;
    for (int d = 0; d < donors; d++) begin
      len = (total == 0 || $urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : total;
      if (len > 70) len = 70;
      room = ITEM_COUNT - sent_items;
      if (room < 1) room = 1;
      if (len > room) len = room;
      fin = (d == donors - 1) || (len == room);
      for (int v = 0; v < len; v++) begin
        dv = rand_value();
        qv = ($urandom_range(0, 2) == 0) ? dv : rand_value();
        case ($urandom_range(0, 3))
          0: mc = dv;
          1: mc = qv;
          default: mc = rand_value();
        endcase
        w = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        sc = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        lv = (v == len - 1);
        // A stray last_donor flag on an inner variable must be ignored.
        send_variable(dv, qv, w, sc, mc, lv,
                      lv ? fin : ($urandom_range(0, 9) == 0));
      end
      if (fin) break;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; s_tuser = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one variable of each kind, extreme values, semi-continuous cases,
    // an equal-distance tie and more neighbours than donors, then k of zero and of 31.
    configure(1, 1, 1, 1, 16, 16'hFFFF);
    send_variable(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
    send_variable(32'd5, 32'd6, 16'hFFFF, 0, 0, 0, 1);
    send_variable(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 0, 0, 0);
    send_variable(32'd9, 32'd7, 16'h0100, 0, 32'd9, 1, 0);
    send_variable(32'd0, 32'd0, 16'hFFFF, 0, 0, 0, 0);
    send_variable(32'd3, 32'd3, 16'hFFFF, 0, 0, 0, 0);
    send_variable(32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
    send_variable(32'd4, 32'd4, 16'h0100, 0, 32'd4, 1, 0);
    send_variable(32'd0, 32'd0, 16'hFFFF, 0, 0, 0, 0);
    send_variable(32'd3, 32'd3, 16'hFFFF, 0, 0, 0, 0);
    send_variable(32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 0, 0, 0);
    send_variable(32'd8, 32'd1, 16'h0000, 0, 32'd2, 1, 1);
    configure(0, 0, 0, 0, 0, 0);
    send_variable(32'd1, 32'd2, 16'h1234, 16'h1, 32'd1, 1, 1);
    configure(64, 0, 0, 0, 31, 16'hFFFF);
    send_variable(32'd1, 32'd9, 16'h1, 16'h1, 32'd1, 1, 1);

    while (sent_items < ITEM_COUNT) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 5) == 0)
          configure(($urandom_range(0, 1) ? 7'd64 : 7'd127), 7'($urandom_range(0, 2)),
                    7'($urandom_range(0, 2)), 7'($urandom_range(0, 2)),
                    5'($urandom_range(0, 31)), 16'($urandom));
        else
          configure(7'($urandom_range(0, 3)), 7'($urandom_range(0, 3)),
                    7'($urandom_range(0, 3)), 7'($urandom_range(0, 3)),
                    5'($urandom_range(0, 18)),
                    ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1) * 16'hFFFF)
                                                : 16'($urandom));
      end
      run_query($urandom_range(1, 6));
    end
    s_tvalid <= 1'b0;

    while (ranker.pending_neighbours.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ranker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gkn_pkg.sv
rtl/gkn_term.sv
rtl/gkn_cell.sv
rtl/gower_k_nearest_donors_top.sv
tb/sv/testbench.sv
